>>> hw/rtl/pnq_pkg.sv
// Shared types and constants of the priority notification queue.
package pnq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int FILL_W              = 5;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [31:0] message;
        logic [1:0]  kind;
        logic [7:0]  prio;
    } entry_t;

    // Broadcast to every cell on an accepted item that changes the queue.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/pnq_req_if.sv
// Request channel of the priority notification queue.
interface pnq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  task_index;
    logic [31:0] message_word;
    logic [1:0]  note_kind;
    logic [7:0]  prio_level;

    modport source (
        output valid, req_type, task_index, message_word, note_kind, prio_level,
        input  ready
    );
    modport sink (
        input  valid, req_type, task_index, message_word, note_kind, prio_level,
        output ready
    );
endinterface

>>> hw/rtl/pnq_rsp_if.sv
// Response channel of the priority notification queue.
interface pnq_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [7:0]  head_task;
    logic [31:0] head_message;
    logic [1:0]  head_kind;
    logic [7:0]  head_prio;
    logic [4:0]  fill_count;

    modport source (
        output valid, accepted, head_task, head_message, head_kind, head_prio, fill_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, head_task, head_message, head_kind, head_prio, fill_count,
        output ready
    );
endinterface

>>> hw/rtl/priority_notification_queue.sv
// Top level of the priority notification queue: cell chain, count and response register.
//
//   channel | modport | moves
//   --------+---------+-------------------------------------------
//   req     | sink    | push / pop / peek request item
//   rsp     | source  | one response item per request
//
// The cell chain handles each request; the response sits in an
// output register, so a new item is taken every cycle while rsp is drained.
// The whole chain compares against the new priority in parallel.
// Reset clears the entry count and the response valid; entries need no clearing.
// A stalled response holds, and req.ready drops only while it is stalled.
module priority_notification_queue #(
    parameter int QUEUE_DEPTH = pnq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    pnq_req_if.sink req,
    pnq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                ok_next;
    pnq_pkg::entry_t     head_next;
    logic                ok_reg;
    pnq_pkg::entry_t     head_reg;
    logic [pnq_pkg::FILL_W-1:0] fill_reg;

    logic                take;
    logic                full;
    logic                empty;
    pnq_pkg::entry_t     new_entry;
    pnq_pkg::cell_ctrl_t ctrl;

    pnq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic                cell_cond  [QUEUE_DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign new_entry.task_id = req.task_index;
    assign new_entry.message = req.message_word;
    assign new_entry.kind    = req.note_kind;
    assign new_entry.prio    = req.prio_level;

    assign ctrl.push = take && (req.req_type == pnq_pkg::REQ_PUSH) && !full;
    assign ctrl.pop  = take && (req.req_type == pnq_pkg::REQ_POP) && !empty;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        pnq_pkg::entry_t left_entry;
        pnq_pkg::entry_t right_entry;
        logic            left_cond;
        logic            occupied;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_cond  = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_cond  = cell_cond[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        pnq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (occupied),
            .left_cond   (left_cond),
            .entry       (cell_entry[i]),
            .cond        (cell_cond[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        head_next  = '0;
        case (req.req_type)
            pnq_pkg::REQ_PUSH:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            pnq_pkg::REQ_POP:
            begin
                if (!empty)
                begin
                    ok_next    = 1'b1;
                    head_next  = cell_entry[0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            pnq_pkg::REQ_PEEK:
            begin
                if (!empty)
                begin
                    ok_next   = 1'b1;
                    head_next = cell_entry[0];
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload: load on every accepted item, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ok_reg   <= ok_next;
            head_reg <= head_next;
            fill_reg <= pnq_pkg::FILL_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.accepted     = ok_reg;
    assign rsp.head_task    = head_reg.task_id;
    assign rsp.head_message = head_reg.message;
    assign rsp.head_kind    = head_reg.kind;
    assign rsp.head_prio    = head_reg.prio;
    assign rsp.fill_count   = fill_reg;

endmodule

>>> hw/rtl/pnq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module pnq_cell (
    input  logic               clk,
    input  pnq_pkg::cell_ctrl_t ctrl,
    input  pnq_pkg::entry_t    new_entry,
    input  pnq_pkg::entry_t    left_entry,
    input  pnq_pkg::entry_t    right_entry,
    input  logic               occupied,
    input  logic               left_cond,
    output pnq_pkg::entry_t    entry,
    output logic               cond
);

    pnq_pkg::entry_t entry_reg;
    pnq_pkg::entry_t entry_next;

    // True where the new entry belongs at or ahead of this slot.
    assign cond  = !occupied || (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (cond && left_cond)
            begin
                entry_next = left_entry;
            end
            else if (cond)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
